// ===== sv/spdx_pkg.sv =====
// Package: shared types, codes and constants for the string pool deframer.
`default_nettype none
package spdx_pkg;

    // Phase codes of the deframer
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_DONE    = 3'd3;
    localparam logic [2:0] PH_BAD     = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_EMPTY  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // End status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_TRUNCATED  = 2'd2;

    // Header word numbers
    localparam logic [1:0] HW_MAGIC   = 2'd0;
    localparam logic [1:0] HW_VERSION = 2'd1;
    localparam logic [1:0] HW_COUNT   = 2'd2;

    // Register indexes (byte address 4*i)
    localparam logic [1:0] REG_MAGIC   = 2'd0;
    localparam logic [1:0] REG_VERSION = 2'd1;
    localparam logic [1:0] REG_SEED    = 2'd2;
    localparam logic [1:0] REG_STEP    = 2'd3;

    // Register reset values
    localparam logic [31:0] MAGIC_RESET   = 32'h4153_5452;
    localparam logic [31:0] VERSION_RESET = 32'd1;
    localparam logic [7:0]  SEED_RESET    = 8'ha7;
    localparam logic [7:0]  STEP_RESET    = 8'd31;

    // Result queue geometry
    localparam int QDEPTH = 8;
    localparam int QPTR_W = 3;
    localparam int QCNT_W = 4;

    typedef struct packed {
        logic [7:0] blob_byte;
        logic       blob_end;
    } blob_req_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  plain_byte;
        logic [31:0] record_number;
        logic        record_done;
        logic [1:0]  end_status;
    } result_t;

    typedef struct packed {
        logic [31:0] expected_magic;
        logic [31:0] expected_version;
        logic [7:0]  key_seed;
        logic [7:0]  key_step;
    } cfg_t;

    // Up to two results pushed per item; v1 implies v0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t e0;
        result_t e1;
    } push_t;

endpackage
`default_nettype wire

// ===== sv/spdx_core.sv =====
// Deframer core: input register, header/record state and result generation.
`default_nettype none
module spdx_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          blob_valid,
    output logic                               blob_ready,
    input  wire spdx_pkg::blob_req_t           blob_req,
    input  wire spdx_pkg::cfg_t                cfg,
    input  wire logic [spdx_pkg::QCNT_W-1:0]   q_count,
    output spdx_pkg::push_t                    push
);
    import spdx_pkg::*;

    logic            in_valid_reg;
    blob_req_t       in_req_reg;
    logic [2:0]      phase_reg, phase_next;
    logic [1:0]      biw_reg, biw_next;
    logic [1:0]      hw_reg, hw_next;
    logic [31:0]     word_reg, word_next;
    logic [31:0]     total_reg, total_next;
    logic [31:0]     seen_reg, seen_next;
    logic [31:0]     left_reg, left_next;
    logic [7:0]      key_reg, key_next;
    logic [31:0]     shifted;
    logic [31:0]     seen_inc;
    logic [31:0]     left_dec;
    logic            word_full;
    logic [QCNT_W:0] room_need;

    // Accept a request only while the queue can absorb this and the staged item
    assign room_need  = {1'b0, q_count} + {{(QCNT_W-1){1'b0}}, in_valid_reg, 1'b0};
    assign blob_ready = room_need <= (QCNT_W+1)'(QDEPTH - 2);

    // Hold the input request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= blob_valid && blob_ready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (blob_valid && blob_ready)
        begin
            in_req_reg <= blob_req;
        end
    end

    assign shifted   = {word_reg[23:0], in_req_reg.blob_byte};
    assign word_full = (biw_reg == 2'd3);
    assign seen_inc  = seen_reg + 32'd1;
    assign left_dec  = left_reg - 32'd1;

    // Advance the deframer by one byte
    always_comb
    begin
        phase_next = phase_reg;
        biw_next   = biw_reg;
        hw_next    = hw_reg;
        word_next  = word_reg;
        total_next = total_reg;
        seen_next  = seen_reg;
        left_next  = left_reg;
        key_next   = key_reg;
        push       = '0;
        if (in_valid_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    word_next = shifted;
                    biw_next  = biw_reg + 2'd1;
                    if (word_full)
                    begin
                        word_next = '0;
                        if (hw_reg == HW_MAGIC)
                        begin
                            phase_next = (shifted == cfg.expected_magic) ? PH_HEADER : PH_BAD;
                            hw_next    = HW_VERSION;
                        end
                        else if (hw_reg == HW_VERSION)
                        begin
                            phase_next = (shifted == cfg.expected_version) ? PH_HEADER : PH_BAD;
                            hw_next    = HW_COUNT;
                        end
                        else
                        begin
                            total_next = shifted;
                            seen_next  = '0;
                            hw_next    = HW_MAGIC;
                            phase_next = (shifted == 32'd0) ? PH_DONE : PH_LENGTH;
                        end
                    end
                end
                PH_LENGTH:
                begin
                    word_next = shifted;
                    biw_next  = biw_reg + 2'd1;
                    if (word_full)
                    begin
                        left_next = shifted;
                        word_next = '0;
                        key_next  = cfg.key_seed;
                        if (shifted == 32'd0)
                        begin
                            push.v0               = 1'b1;
                            push.e0.result_kind   = KIND_EMPTY;
                            push.e0.record_number = seen_reg;
                            seen_next             = seen_inc;
                            phase_next = (seen_inc >= total_reg) ? PH_DONE : PH_LENGTH;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    push.v0               = 1'b1;
                    push.e0.result_kind   = KIND_BYTE;
                    push.e0.plain_byte    = in_req_reg.blob_byte ^ key_reg;
                    push.e0.record_number = seen_reg;
                    key_next              = key_reg + cfg.key_step;
                    left_next             = left_dec;
                    if (left_dec == 32'd0)
                    begin
                        push.e0.record_done = 1'b1;
                        seen_next           = seen_inc;
                        phase_next = (seen_inc >= total_reg) ? PH_DONE : PH_LENGTH;
                    end
                end
                default:
                begin
                    // Done, bad and unused phases drop the byte
                end
            endcase

            // Close the blob: report status, then return to reset state
            if (in_req_reg.blob_end)
            begin
                if (push.v0)
                begin
                    push.v1                = 1'b1;
                    push.e1.result_kind    = KIND_STATUS;
                end
                else
                begin
                    push.v0                = 1'b1;
                    push.e0.result_kind    = KIND_STATUS;
                end
                if (phase_next == PH_DONE)
                begin
                    push.e1.end_status = ST_OK;
                end
                else if (phase_next == PH_LENGTH || phase_next == PH_PAYLOAD)
                begin
                    push.e1.end_status = ST_TRUNCATED;
                end
                else
                begin
                    push.e1.end_status = ST_BAD_HEADER;
                end
                if (!push.v1)
                begin
                    push.e0.end_status = push.e1.end_status;
                    push.e1.end_status = ST_OK;
                end
                phase_next = PH_HEADER;
                biw_next   = '0;
                hw_next    = HW_MAGIC;
                word_next  = '0;
                total_next = '0;
                seen_next  = '0;
                left_next  = '0;
                key_next   = '0;
            end
        end
    end

    // Update deframer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            biw_reg   <= '0;
            hw_reg    <= HW_MAGIC;
            word_reg  <= '0;
            total_reg <= '0;
            seen_reg  <= '0;
            left_reg  <= '0;
            key_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            biw_reg   <= biw_next;
            hw_reg    <= hw_next;
            word_reg  <= word_next;
            total_reg <= total_next;
            seen_reg  <= seen_next;
            left_reg  <= left_next;
            key_reg   <= key_next;
        end
    end

    // A payload phase always has bytes left to take
    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> left_reg != 32'd0)
        else $error("payload phase with no bytes left");

    // A status result returns the deframer to the header phase
    a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_req_reg.blob_end |=> phase_reg == PH_HEADER && biw_reg == 2'd0)
        else $error("state not cleared after end of blob");

    // A second result only comes with the end of the blob
    a_second_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> in_valid_reg && in_req_reg.blob_end && push.e1.result_kind == KIND_STATUS)
        else $error("second result without end of blob");

    // The staged item never finds the queue short of room
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> q_count <= QCNT_W'(QDEPTH - 2))
        else $error("result queue overrun risk");

endmodule
`default_nettype wire

// ===== sv/spdx_resq.sv =====
// Result queue: takes up to two results per cycle, hands out one.
`default_nettype none
module spdx_resq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire spdx_pkg::push_t               push,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output spdx_pkg::result_t                  result,
    output logic [spdx_pkg::QCNT_W-1:0]        count
);
    import spdx_pkg::*;

    result_t           slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [QPTR_W-1:0] wr_plus1;
    logic [QCNT_W-1:0] n_push;
    logic              pop;

    assign wr_plus1     = wr_reg + QPTR_W'(1);
    assign n_push       = QCNT_W'(push.v0) + QCNT_W'(push.v1);
    assign pop          = result_valid && result_ready;
    assign result_valid = cnt_reg != '0;
    assign result       = slot_reg[rd_reg];
    assign count        = cnt_reg;

    assign wr_next  = wr_reg + n_push[QPTR_W-1:0];
    assign rd_next  = rd_reg + QPTR_W'(pop);
    assign cnt_next = cnt_reg + n_push - QCNT_W'(pop);

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            slot_reg[wr_reg] <= push.e0;
        end
        if (push.v1)
        begin
            slot_reg[wr_plus1] <= push.e1;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Fill count stays within the queue
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // Pointers and count stay in step
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_reg - rd_reg) == cnt_reg[QPTR_W-1:0])
        else $error("queue pointers out of step");

    // A second push never comes alone
    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> push.v0)
        else $error("second result without first");

endmodule
`default_nettype wire

// ===== sv/string_pool_deframe_xor_decode.sv =====
// Top level: string pool deframer and XOR decoder with APB registers.
//
//  Channel  | Signals                                    | Direction
//  blob     | blob_valid, blob_ready, blob_req           | in
//  result   | result_valid, result_ready, result         | out
//  config   | psel, penable, pwrite, paddr, pwdata,      | APB
//           | prdata, pready                             |
//
// One blob byte is taken per cycle while blob_ready is high; it is held in the
// input register and its results go from there into the result queue. A byte
// that yields two results (last payload byte or empty length word plus end
// status) queues both for the result port. blob_ready drops while the eight-entry
// result queue, counting two results for the staged request, has room for fewer than two more.
// Reset clears all deframer state and loads the register reset values.
`default_nettype none
module string_pool_deframe_xor_decode (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 blob_valid,
    output logic                      blob_ready,
    input  wire spdx_pkg::blob_req_t  blob_req,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output spdx_pkg::result_t         result,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import spdx_pkg::*;

    cfg_t              cfg_reg;
    push_t             push;
    logic [QCNT_W-1:0] q_count;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_magic   <= MAGIC_RESET;
            cfg_reg.expected_version <= VERSION_RESET;
            cfg_reg.key_seed         <= SEED_RESET;
            cfg_reg.key_step         <= STEP_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MAGIC:   cfg_reg.expected_magic   <= pwdata;
                REG_VERSION: cfg_reg.expected_version <= pwdata;
                REG_SEED:    cfg_reg.key_seed         <= pwdata[7:0];
                REG_STEP:    cfg_reg.key_step         <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        case (reg_idx)
            REG_MAGIC:   prdata = cfg_reg.expected_magic;
            REG_VERSION: prdata = cfg_reg.expected_version;
            REG_SEED:    prdata = {24'd0, cfg_reg.key_seed};
            REG_STEP:    prdata = {24'd0, cfg_reg.key_step};
            default:     prdata = '0;
        endcase
    end

    spdx_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .blob_valid (blob_valid),
        .blob_ready (blob_ready),
        .blob_req   (blob_req),
        .cfg        (cfg_reg),
        .q_count    (q_count),
        .push       (push)
    );

    spdx_resq u_resq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .count        (q_count)
    );

endmodule
`default_nettype wire
